[design/mkrs_pkg.sv]
package mkrs_pkg;

    localparam int POS_W = 6;
    localparam int SPEC_W = 3;
    localparam int NAME_W = 64;
    localparam int COURSE_W = 4;

    typedef struct packed {
        logic [SPEC_W-1:0]   spec;
        logic [NAME_W-1:0]   name_hi;
        logic [NAME_W-1:0]   name_lo;
        logic [COURSE_W-1:0] course;
        logic [POS_W-1:0]    pos;
    } record_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic shift_out;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    // keep the first `keep` bytes of a word, first byte in the top bits
    function automatic logic [NAME_W-1:0] byte_mask(input int keep);
        logic [NAME_W-1:0] m;
        m = '0;
        if (keep >= 8)
            m = '1;
        else if (keep > 0)
            m = {NAME_W{1'b1}} << (NAME_W - 8 * keep);
        return m;
    endfunction

    // strict "a sorts after b": specialty, then surname bytes, then course
    function automatic logic key_after(input record_t a, input record_t b);
        return {a.spec, a.name_hi, a.name_lo, a.course} >
               {b.spec, b.name_hi, b.name_lo, b.course};
    endfunction

endpackage

[design/mkrs_cell.sv]
module mkrs_cell (
    input  logic                clk,
    input  mkrs_pkg::cell_ctl_t ctl,
    input  logic                occupied,
    input  mkrs_pkg::record_t   new_rec,
    input  logic                prev_take,
    input  mkrs_pkg::record_t   prev_rec,
    input  mkrs_pkg::record_t   next_rec,
    output logic                take,
    output mkrs_pkg::record_t   rec
);

    mkrs_pkg::record_t rec_reg;
    mkrs_pkg::record_t rec_next;

    // cell moves on insert if it holds a larger key or is empty
    assign take = !occupied || mkrs_pkg::key_after(rec_reg, new_rec);

    always_comb
    begin
        rec_next = rec_reg;
        if (ctl.insert && take)
            rec_next = prev_take ? prev_rec : new_rec;
        else if (ctl.shift_out)
            rec_next = next_rec;
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule

[design/multikey_record_index_sort.sv]
// Stable multikey record index sorter, built as a chain of insertion cells.
// Fill: one record transfer per cycle; each record lands in its sorted cell
// in the cycle it is taken (all cells compare against it at once).
// Drain: after the final record, one index per cycle from cell 0 while out_ready
// is high, first index the cycle after that transfer; input is held off meanwhile.
// Reset (rst_n low, async) clears the count and state; cell contents are not reset.
module multikey_record_index_sort #(
    parameter int MAX_RECORDS = 64,
    parameter int NAME_BYTES  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [mkrs_pkg::SPEC_W-1:0]      specialty,
    input  logic [mkrs_pkg::NAME_W-1:0]      surname_high,
    input  logic [mkrs_pkg::NAME_W-1:0]      surname_low,
    input  logic [mkrs_pkg::COURSE_W-1:0]    course,
    input  logic                             final_record,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [mkrs_pkg::POS_W-1:0]       record_position,
    output logic                             final_position
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    // bytes past NAME_BYTES never take part in the compare
    localparam logic [mkrs_pkg::NAME_W-1:0] HI_MASK = mkrs_pkg::byte_mask(NAME_BYTES);
    localparam logic [mkrs_pkg::NAME_W-1:0] LO_MASK = mkrs_pkg::byte_mask(NAME_BYTES - 8);

    mkrs_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    mkrs_pkg::record_t new_rec;
    mkrs_pkg::cell_ctl_t ctl;
    logic              in_xfer;
    logic              out_xfer;
    logic              has_room;

    mkrs_pkg::record_t cell_rec  [MAX_RECORDS];
    logic              cell_take [MAX_RECORDS];

    assign in_ready  = (state_reg == mkrs_pkg::ST_FILL);
    assign out_valid = (state_reg == mkrs_pkg::ST_DRAIN);
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid && out_ready;
    // a record arriving with the store full is dropped
    assign has_room  = (count_reg < CNT_W'(MAX_RECORDS));

    // new record; its arrival index is the current fill count
    always_comb
    begin
        new_rec.spec    = specialty;
        new_rec.name_hi = surname_high & HI_MASK;
        new_rec.name_lo = surname_low & LO_MASK;
        new_rec.course  = course;
        new_rec.pos     = mkrs_pkg::POS_W'(count_reg);
    end

    assign ctl.insert    = in_xfer && has_room;
    assign ctl.shift_out = out_xfer;

    // The chain: cells 0..count-1 hold records in sorted order. On insert every
    // cell with a strictly larger key (or empty) steps one place right and the
    // new record drops into the first such cell, which keeps ties in arrival
    // order. On drain every cell but the last takes its right neighbor's record.
    for (genvar i = 0; i < MAX_RECORDS; i++)
    begin : g_cell
        logic              occ;
        logic              p_take;
        mkrs_pkg::record_t p_rec;
        mkrs_pkg::record_t n_rec;

        assign occ = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign p_take = 1'b0;
            assign p_rec  = new_rec;
        end
        else
        begin : g_body
            assign p_take = cell_take[i-1];
            assign p_rec  = cell_rec[i-1];
        end

        if (i == MAX_RECORDS - 1)
        begin : g_tail
            assign n_rec = cell_rec[i];
        end
        else
        begin : g_mid
            assign n_rec = cell_rec[i+1];
        end

        mkrs_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .occupied  (occ),
            .new_rec   (new_rec),
            .prev_take (p_take),
            .prev_rec  (p_rec),
            .next_rec  (n_rec),
            .take      (cell_take[i]),
            .rec       (cell_rec[i])
        );
    end

    // during drain count_reg is the number of indices still to go
    assign record_position = cell_rec[0].pos;
    assign final_position  = (count_reg == CNT_W'(1));

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            mkrs_pkg::ST_FILL:
            begin
                if (ctl.insert)
                    count_next = count_reg + CNT_W'(1);
                if (in_xfer && final_record)
                    state_next = mkrs_pkg::ST_DRAIN;
            end
            mkrs_pkg::ST_DRAIN:
            begin
                if (out_xfer)
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (final_position)
                        state_next = mkrs_pkg::ST_FILL;
                end
            end
            default:
            begin
                state_next = mkrs_pkg::ST_FILL;
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mkrs_pkg::ST_FILL;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");

    a_final_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && final_record) |=> (out_valid && count_reg != '0))
        else $error("final record did not start drain");

    a_drain_ends_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && final_position) |=> (in_ready && count_reg == '0))
        else $error("drain did not end empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RECORDS))
        else $error("record count over capacity");
`endif

endmodule

[verif/tb.sv]
// Self-checking bench for multikey_record_index_sort.
// Records go in on the input channel. After the final record of a set, the
// block streams back the arrival indices in sorted order. A local insertion
// model mirrors the sort and queues the indices it expects. The output monitor
// checks every transfer against the oldest queued index.
module tb;

    localparam int MAX_REC  = 64;
    localparam int POS_W    = mkrs_pkg::POS_W;
    localparam int SPEC_W   = mkrs_pkg::SPEC_W;
    localparam int NAME_W   = mkrs_pkg::NAME_W;
    localparam int COURSE_W = mkrs_pkg::COURSE_W;

    // surname words with a few shared prefixes, so that ties and
    // single-byte differences are common
    localparam logic [NAME_W-1:0] NAME_ADAMS   = 64'h4144_414D_5300_0000;
    localparam logic [NAME_W-1:0] NAME_ADAMSON = 64'h4144_414D_534F_4E00;
    localparam logic [NAME_W-1:0] NAME_MILLER  = 64'h4D49_4C4C_4552_0000;
    localparam logic [NAME_W-1:0] NAME_TOP_BIT = 64'h8000_0000_0000_0000;

    // one sorted index the block should return
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             last;
    } sorted_idx_t;

    // one row of the directed table; typed rows carry their expected index
    typedef struct packed {
        logic [SPEC_W-1:0]   spec;
        logic [NAME_W-1:0]   hi;
        logic [NAME_W-1:0]   lo;
        logic [COURSE_W-1:0] course;
        logic                fin;
        logic                typed;
        logic [POS_W-1:0]    typed_pos;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [SPEC_W-1:0]   specialty = '0;
    logic [NAME_W-1:0]   surname_high = '0;
    logic [NAME_W-1:0]   surname_low = '0;
    logic [COURSE_W-1:0] course = '0;
    logic                final_record = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [POS_W-1:0]    record_position;
    logic                final_position;

    // local copy of the sorted store
    mkrs_pkg::record_t held [MAX_REC];
    int                held_count = 0;

    sorted_idx_t sorted_idx_q[$];
    int          mismatches = 0;

    // idle odds in percent, per side
    int send_idle = 0;
    int recv_idle = 0;

    dir_row_t dir_rows [15];

    multikey_record_index_sort u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .specialty       (specialty),
        .surname_high    (surname_high),
        .surname_low     (surname_low),
        .course          (course),
        .final_record    (final_record),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .record_position (record_position),
        .final_position  (final_position)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // true when a held record sorts strictly after the incoming key:
    // specialty first, then the surname bytes in order, then course
    function automatic bit sorts_after(input mkrs_pkg::record_t e,
                                       input logic [SPEC_W-1:0] sp,
                                       input logic [NAME_W-1:0] hi,
                                       input logic [NAME_W-1:0] lo,
                                       input logic [COURSE_W-1:0] co);
        if (e.spec != sp)
            return e.spec > sp;
        if (e.name_hi != hi)
            return e.name_hi > hi;
        if (e.name_lo != lo)
            return e.name_lo > lo;
        return e.course > co;
    endfunction

    // Insert one accepted record into the local store. Equal keys stop the
    // shift, so arrival order is kept. A full store drops the record. On a
    // final record, queue every held index in order, unless the caller
    // typed the expected index in by hand.
    function automatic void file_record(input logic [SPEC_W-1:0] sp,
                                        input logic [NAME_W-1:0] hi,
                                        input logic [NAME_W-1:0] lo,
                                        input logic [COURSE_W-1:0] co,
                                        input logic fin, input bit emit);
        int j;
        sorted_idx_t idx;
        if (held_count < MAX_REC)
        begin
            j = held_count;
            while (j > 0 && sorts_after(held[j-1], sp, hi, lo, co))
            begin
                held[j] = held[j-1];
                j--;
            end
            held[j].spec    = sp;
            held[j].name_hi = hi;
            held[j].name_lo = lo;
            held[j].course  = co;
            held[j].pos     = held_count[POS_W-1:0];
            held_count++;
        end
        if (fin)
        begin
            if (emit)
                for (int k = 0; k < held_count; k++)
                begin
                    idx.pos  = held[k].pos;
                    idx.last = (k == held_count - 1);
                    sorted_idx_q.push_back(idx);
                end
            held_count = 0;
        end
    endfunction

    function automatic dir_row_t mk_row(input logic [SPEC_W-1:0] sp,
                                        input logic [NAME_W-1:0] hi,
                                        input logic [NAME_W-1:0] lo,
                                        input logic [COURSE_W-1:0] co,
                                        input logic fin, input logic typed,
                                        input logic [POS_W-1:0] tpos);
        dir_row_t r;
        r.spec = sp;
        r.hi = hi;
        r.lo = lo;
        r.course = co;
        r.fin = fin;
        r.typed = typed;
        r.typed_pos = tpos;
        return r;
    endfunction

    // Drive one record and wait for its transfer. A random gap first drops
    // valid; otherwise valid stays high straight from the previous record.
    task automatic send(input logic [SPEC_W-1:0] sp, input logic [NAME_W-1:0] hi,
                        input logic [NAME_W-1:0] lo, input logic [COURSE_W-1:0] co,
                        input logic fin, input bit emit);
        if ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle);
        end
        in_valid     <= 1'b1;
        specialty    <= sp;
        surname_high <= hi;
        surname_low  <= lo;
        course       <= co;
        final_record <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        file_record(sp, hi, lo, co, fin, emit);
    endtask

    // sender goes quiet until every queued index has come back
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (sorted_idx_q.size() != 0)
            @(posedge clk);
    endtask

    // mostly pooled words, so that neighbors tie; sometimes fully random
    function automatic logic [NAME_W-1:0] rand_word();
        case ($urandom_range(0, 6))
            0: return {$urandom, $urandom};
            1: return '0;
            2: return '1;
            3: return NAME_ADAMS;
            4: return NAME_ADAMSON;
            5: return NAME_MILLER;
            default: return NAME_TOP_BIT | NAME_W'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic random_set(input int len);
        logic [SPEC_W-1:0]   sp;
        logic [COURSE_W-1:0] co;
        for (int i = 0; i < len; i++)
        begin
            // codes five to seven are legal encodings and get some traffic
            sp = ($urandom_range(0, 9) < 8) ? SPEC_W'($urandom_range(0, 4))
                                            : SPEC_W'($urandom_range(5, 7));
            co = ($urandom_range(0, 3) == 0) ? COURSE_W'($urandom_range(0, 15))
                                             : COURSE_W'($urandom_range(0, 2));
            send(sp, rand_word(), rand_word(), co, i == len - 1, 1'b1);
        end
    endtask

    // output monitor: every transfer must match the oldest queued index
    always @(posedge clk)
    begin : idx_check
        sorted_idx_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (sorted_idx_q.size() == 0)
            begin
                $error("transfer with nothing queued: record_position=%0d final_position=%0d",
                       record_position, final_position);
                mismatches++;
            end
            else
            begin
                want = sorted_idx_q.pop_front();
                if (record_position !== want.pos)
                begin
                    $error("record_position: expected %0d, got %0d", want.pos, record_position);
                    mismatches++;
                end
                if (final_position !== want.last)
                begin
                    $error("final_position: expected %0d, got %0d", want.last, final_position);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int sent;
        int len;
        sorted_idx_t idx;

        // Directed table. The first two rows are one-record sets right after
        // reset, with the lowest and highest keys; their single index is 0
        // and it is flagged last. The rest build two sets that hit every key
        // level, exact ties, and specialty codes beyond the normal range.
        dir_rows[0]  = mk_row(0, '0, '0, 0, 1'b1, 1'b1, 0);
        dir_rows[1]  = mk_row(7, '1, '1, 15, 1'b1, 1'b1, 0);
        dir_rows[2]  = mk_row(3, NAME_MILLER, '0, 2, 1'b0, 1'b0, 0);
        dir_rows[3]  = mk_row(3, NAME_MILLER, '0, 2, 1'b0, 1'b0, 0);
        dir_rows[4]  = mk_row(3, NAME_MILLER, '0, 1, 1'b0, 1'b0, 0);
        dir_rows[5]  = mk_row(3, NAME_MILLER, 64'h1, 0, 1'b0, 1'b0, 0);
        dir_rows[6]  = mk_row(3, NAME_ADAMS, '0, 9, 1'b0, 1'b0, 0);
        dir_rows[7]  = mk_row(1, '1, '1, 15, 1'b0, 1'b0, 0);
        dir_rows[8]  = mk_row(5, '0, '0, 0, 1'b0, 1'b0, 0);
        dir_rows[9]  = mk_row(6, NAME_ADAMSON, '0, 4, 1'b0, 1'b0, 0);
        dir_rows[10] = mk_row(7, '0, '0, 0, 1'b0, 1'b0, 0);
        dir_rows[11] = mk_row(0, '0, '0, 0, 1'b0, 1'b0, 0);
        dir_rows[12] = mk_row(3, NAME_MILLER, '0, 2, 1'b1, 1'b0, 0);
        dir_rows[13] = mk_row(4, NAME_TOP_BIT, 64'h1, 3, 1'b0, 1'b0, 0);
        dir_rows[14] = mk_row(4, NAME_TOP_BIT, '0, 3, 1'b1, 1'b0, 0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 13;
        recv_idle = 65;
        foreach (dir_rows[i])
        begin
            send(dir_rows[i].spec, dir_rows[i].hi, dir_rows[i].lo, dir_rows[i].course,
                 dir_rows[i].fin, !dir_rows[i].typed);
            if (dir_rows[i].typed)
            begin
                idx.pos  = dir_rows[i].typed_pos;
                idx.last = 1'b1;
                sorted_idx_q.push_back(idx);
            end
        end
        hold_until_drained();

        // Three random phases: slow receiver, then slow sender, then no idling.
        // Each opens with a set at or past the store size, so any extra records
        // are dropped while the final one still triggers the output.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 13 : (ph == 1) ? 65 : 0;
            recv_idle = (ph == 0) ? 65 : (ph == 1) ? 13 : 0;
            random_set($urandom_range(MAX_REC, MAX_REC + 6));
            sent = 0;
            while (sent < 100)
            begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                random_set(len);
                sent += len;
                if ($urandom_range(0, 9) == 0)
                    hold_until_drained();
            end
            hold_until_drained();
        end

        // settle, so any stray transfer still gets caught
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #10000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
